[rtl/shs_pkg.sv]
// shared types, constants and round functions for the sha-256 stream hasher
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

    typedef logic [7:0][31:0]  work_t;
    typedef logic [15:0][31:0] window_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_EMIT
    } st_t;

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } sel_t;

    typedef struct packed {
        logic push_en;
        sel_t byte_sel;
        logic word_push;
        logic cnt_inc;
        logic len_load;
        logic start_comp;
        logic round_en;
        logic fold;
        logic emit_shift;
        logic finish;
    } ctrl_t;

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LAST_POS   = 6'd63;
    localparam logic [5:0]  LEN_POS    = 6'd55;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [2:0]  LAST_IDX   = 3'd7;

    localparam work_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

endpackage

`default_nettype wire

[rtl/shs_round.sv]
// one sha-256 compression round and message schedule step
`timescale 1ns / 1ps
`default_nettype none

module shs_round
    import shs_pkg::*;
(
    input  work_t       work_in,
    input  window_t     window,
    input  logic [5:0]  round,
    output work_t       work_out,
    output logic [31:0] w_next
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign ch  = work_in[6] ^ (work_in[4] & (work_in[5] ^ work_in[6]));
    assign maj = (work_in[0] & work_in[1]) | (work_in[2] & (work_in[0] | work_in[1]));
    assign t1  = work_in[7] + big_s1(work_in[4]) + ch + round_k(round) + window[0];
    assign t2  = big_s0(work_in[0]) + maj;

    assign w_next = small_s1(window[14]) + window[9] + small_s0(window[1]) + window[0];

    always_comb
    begin
        work_out[7] = work_in[6];
        work_out[6] = work_in[5];
        work_out[5] = work_in[4];
        work_out[4] = work_in[3] + t1;
        work_out[3] = work_in[2];
        work_out[2] = work_in[1];
        work_out[1] = work_in[0];
        work_out[0] = t1 + t2;
    end

endmodule

`default_nettype wire

[rtl/shs_ctrl.sv]
// sequencer for byte loading, padding, compression rounds and digest output
`timescale 1ns / 1ps
`default_nettype none

module shs_ctrl
    import shs_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_byte_valid,
    input  wire        in_last,
    input  wire        out_ready,
    output logic       in_ready,
    output logic       out_valid,
    output logic [5:0] round,
    output logic [2:0] idx,
    output ctrl_t      ctrl
);

    st_t        state_reg, state_next;
    st_t        ret_reg, ret_next;
    logic [5:0] pos_reg, pos_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            pos_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pos_next   = pos_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        ctrl       = '0;
        ctrl.byte_sel = SEL_MSG;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_byte_valid)
                    begin
                        ctrl.push_en = 1'b1;
                        ctrl.cnt_inc = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                        if (pos_reg == LAST_POS)
                        begin
                            ctrl.start_comp = 1'b1;
                            round_next      = '0;
                            state_next      = ST_COMP;
                            ret_next        = in_last ? ST_PAD80 : ST_IDLE;
                        end
                        else if (in_last)
                        begin
                            state_next = ST_PAD80;
                        end
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                ctrl.push_en  = 1'b1;
                ctrl.byte_sel = SEL_PAD;
                ctrl.len_load = 1'b1;
                pos_next      = pos_reg + 6'd1;
                priority if (pos_reg == LAST_POS)
                begin
                    ctrl.start_comp = 1'b1;
                    round_next      = '0;
                    state_next      = ST_COMP;
                    ret_next        = ST_PADZ;
                end
                else if (pos_reg == LEN_POS)
                    state_next = ST_LEN;
                else
                    state_next = ST_PADZ;
            end
            ST_PADZ:
            begin
                ctrl.push_en  = 1'b1;
                ctrl.byte_sel = SEL_ZERO;
                pos_next      = pos_reg + 6'd1;
                priority if (pos_reg == LAST_POS)
                begin
                    ctrl.start_comp = 1'b1;
                    round_next      = '0;
                    state_next      = ST_COMP;
                    ret_next        = ST_PADZ;
                end
                else if (pos_reg == LEN_POS)
                    state_next = ST_LEN;
                else
                    state_next = ST_PADZ;
            end
            ST_LEN:
            begin
                ctrl.push_en  = 1'b1;
                ctrl.byte_sel = SEL_LEN;
                pos_next      = pos_reg + 6'd1;
                if (pos_reg == LAST_POS)
                begin
                    ctrl.start_comp = 1'b1;
                    round_next      = '0;
                    state_next      = ST_COMP;
                    ret_next        = ST_EMIT;
                end
            end
            ST_COMP:
            begin
                ctrl.round_en = 1'b1;
                round_next    = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctrl.fold  = 1'b1;
                state_next = ret_reg;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.emit_shift = 1'b1;
                    idx_next        = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        ctrl.finish = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ctrl.word_push = ctrl.push_en && (pos_reg[1:0] == 2'd3);
    end

    assign round = round_reg;
    assign idx   = idx_reg;

endmodule

`default_nettype wire

[rtl/sha256_stream_hasher_top.sv]
// sha-256 stream hasher top level: byte intake, schedule window, state and digest output
//
// input channel s_axis: one item per handshake; tdata is the message byte, tuser flags
// whether that byte is valid, tlast ends the message (a byte with tlast is the last byte).
// an item with tuser low and tlast low does nothing; tuser low with tlast high ends the
// message as it stands, so an empty message is hashed too.
// output channel m_axis: eight items per message, digest words most significant first,
// tuser is the word index and tlast marks word 7.
// throughput: one byte per cycle until a 64-byte block fills, then the shared round unit
// runs 64 rounds and then the fold step with s_axis_tready low.
// after end of message the padder inserts one byte per cycle up to the next 56-byte mark
// (through one extra block when fewer than 9 bytes remain), then 8 length bytes,
// then each padded block is compressed, then the eight words appear one per cycle.
// while m_axis_tready is low the current word holds and nothing else moves;
// s_axis_tready returns high the cycle after word 7 is taken.
// reset: asynchronous, active low; the chaining value returns to the initial hash values
// and the byte count to zero, no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // message_byte
    input  wire         s_axis_tuser,   // byte_valid
    input  wire         s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);

    ctrl_t       ctrl;
    logic [5:0]  round;
    logic [2:0]  idx;

    work_t       hash_reg, hash_next;
    work_t       work_reg, work_next;
    work_t       work_round;
    window_t     window_reg, window_next;
    logic [23:0] acc_reg, acc_next;
    logic [60:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [7:0]  push_byte;
    logic [31:0] w_next;

    shs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_byte_valid (s_axis_tuser),
        .in_last       (s_axis_tlast),
        .out_ready     (m_axis_tready),
        .in_ready      (s_axis_tready),
        .out_valid     (m_axis_tvalid),
        .round         (round),
        .idx           (idx),
        .ctrl          (ctrl)
    );

    shs_round u_round (
        .work_in  (work_reg),
        .window   (window_reg),
        .round    (round),
        .work_out (work_round),
        .w_next   (w_next)
    );

    always_comb
    begin
        unique case (ctrl.byte_sel)
            SEL_MSG:  push_byte = s_axis_tdata;
            SEL_PAD:  push_byte = PAD_BYTE;
            SEL_ZERO: push_byte = 8'h00;
            SEL_LEN:  push_byte = len_reg[63:56];
            default:  push_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        acc_next    = acc_reg;
        window_next = window_reg;
        work_next   = work_reg;
        len_next    = len_reg;

        if (ctrl.push_en)
            acc_next = {acc_reg[15:0], push_byte};
        if (ctrl.word_push)
            window_next = {{acc_reg, push_byte}, window_reg[15:1]};
        else if (ctrl.round_en)
            window_next = {w_next, window_reg[15:1]};

        if (ctrl.start_comp)
            work_next = hash_reg;
        else if (ctrl.round_en)
            work_next = work_round;

        if (ctrl.len_load)
            len_next = {count_reg, 3'b000};
        else if (ctrl.push_en && (ctrl.byte_sel == SEL_LEN))
            len_next = {len_reg[55:0], 8'h00};
    end

    always_comb
    begin
        hash_next  = hash_reg;
        count_next = count_reg;

        if (ctrl.cnt_inc)
            count_next = count_reg + 61'd1;

        priority if (ctrl.finish)
        begin
            hash_next  = HASH_IV;
            count_next = '0;
        end
        else if (ctrl.emit_shift)
            hash_next = {32'h0, hash_reg[7:1]};
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
                hash_next[i] = hash_reg[i] + work_reg[i];
        end
        else
            hash_next = hash_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= HASH_IV;
            count_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        window_reg <= window_next;
        work_reg   <= work_next;
        len_reg    <= len_next;
    end

    assign m_axis_tdata = hash_reg[0];
    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == LAST_IDX);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output active together");

    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after end of message");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("not idle after last digest word");

    a_fresh_state: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
        (hash_reg == HASH_IV && count_reg == 61'd0))
        else $error("chaining value not restarted");

    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tuser == 3'd0))
        else $error("digest does not start at word 0");
`endif

endmodule

`default_nettype wire

[test/sha256_stream_hasher_top_tb.sv]
// testbench for the sha-256 stream hasher: random messages checked against a digest model
`timescale 1ns / 1ps

module sha256_stream_hasher_top_tb;

    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned STIM_TARGET = 180;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [2:0] FINAL_INDEX = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        s_valid = 1'b0;
    msg_item_t   cur_item = '0;
    logic        m_ready = 1'b0;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire [31:0]  m_axis_tdata;
    wire [2:0]   m_axis_tuser;
    wire         m_axis_tlast;

    msg_item_t    pending_items [$];
    msg_item_t    next_item;
    digest_word_t digest_due [$];

    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    logic [60:0] msg_bytes;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;
    int unsigned stim_items = 0;
    bit          steady_src = 1'b0;
    bit          steady_sink = 1'b0;

    sha256_stream_hasher_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (cur_item.data),
        .s_axis_tuser  (cur_item.byte_valid),
        .s_axis_tlast  (cur_item.end_of_message),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sum0(input logic [31:0] x);
        return rot_right(x, 2) ^ rot_right(x, 13) ^ rot_right(x, 22);
    endfunction

    function automatic logic [31:0] sum1(input logic [31:0] x);
        return rot_right(x, 6) ^ rot_right(x, 11) ^ rot_right(x, 25);
    endfunction

    function automatic logic [31:0] gamma0(input logic [31:0] x);
        return rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] gamma1(input logic [31:0] x);
        return rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = gamma1(w[t-2]) + w[t-7] + gamma0(w[t-15]) + w[t-16];
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = START_HASH[i];
        msg_bytes = '0;
    endtask

    task automatic absorb_item(input msg_item_t it);
        int unsigned fill;
        logic [63:0] bit_len;
        digest_word_t dw;
        if (it.byte_valid)
        begin
            block_bytes[msg_bytes[5:0]] = it.data;
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[5:0] == 6'd0)
                compress_block();
        end
        if (it.end_of_message)
        begin
            fill = 32'(msg_bytes[5:0]);
            block_bytes[fill] = PAD_MARK;
            for (int i = fill + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            if (fill >= 56)
            begin
                compress_block();
                for (int i = 0; i < 64; i++)
                    block_bytes[i] = 8'h00;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++)
                block_bytes[56+i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                dw.word = hash_state[i];
                dw.index = i[2:0];
                dw.last = (i[2:0] == FINAL_INDEX);
                digest_due.push_back(dw);
            end
            restart_hash();
        end
    endtask

    task automatic report_error(input string msg);
        $display("error @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_word();
        digest_word_t want;
        if (digest_due.size() == 0)
        begin
            report_error($sformatf("unexpected digest word %08h index %0d",
                                   m_axis_tdata, m_axis_tuser));
            return;
        end
        want = digest_due.pop_front();
        if (m_axis_tdata !== want.word)
            report_error($sformatf("digest_word got %08h want %08h", m_axis_tdata, want.word));
        if (m_axis_tuser !== want.index)
            report_error($sformatf("word_index got %0d want %0d", m_axis_tuser, want.index));
        if (m_axis_tlast !== want.last)
            report_error($sformatf("last_word got %0b want %0b", m_axis_tlast, want.last));
    endtask

    task automatic push_item(input logic [7:0] data, input logic byte_valid, input logic eom);
        msg_item_t it;
        it.data = data;
        it.byte_valid = byte_valid;
        it.end_of_message = eom;
        pending_items.push_back(it);
        stim_items++;
    endtask

    // random bytes with occasional ignored items mixed in
    task automatic queue_message(input int unsigned len);
        bit end_on_byte;
        end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_valid && s_axis_tready)
                absorb_item(cur_item);
            if (!s_valid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    cur_item <= next_item;
                    s_valid <= 1'b1;
                    gap_left <= steady_src ? 0 : idle_len();
                    if ($urandom_range(0, 29) == 0)
                        steady_src <= !steady_src;
                end
                else
                begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_ready)
                check_word();
            if (stall_left != 0)
            begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_ready <= 1'b1;
                if (!steady_sink && $urandom_range(0, 3) == 0)
                    stall_left <= idle_len();
                if ($urandom_range(0, 49) == 0)
                    steady_sink <= !steady_sink;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("sha256_stream_hasher_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        int unsigned len;
        restart_hash();
        for (int i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;

        // ignored item, empty message, single-byte messages at the extremes
        push_item(8'h5a, 1'b0, 1'b0);
        push_item(8'hff, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);
        // "abc" with an ignored item before a separate end
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b0);
        push_item(8'ha5, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h7f, 1'b1, 1'b1);

        // short messages mostly, some at the padding boundaries
        while (stim_items < STIM_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    default: len = 65;
                endcase
            end
            else
            begin
                len = $urandom_range(0, 16);
            end
            if (len > STIM_TARGET - stim_items)
                len = STIM_TARGET - stim_items;
            queue_message(len);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_valid || digest_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sha256_stream_hasher_top_tb OK");
        else
            $display("sha256_stream_hasher_top_tb NOT OK");
        $finish;
    end

endmodule
